[rtl/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// cbt_pkg: shared constants and types for the cubic bezier tessellator
// widths, defaults and the controller/datapath command and status structs
// ----------------------------------------------------------------------------
package cbt_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int GUARD_BITS = 16;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int POS_W = 20;
  localparam int COL_W = 8;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture control points, start step divide
    logic div_step;   // one restoring divide iteration
    logic pt_start;   // latch t for the current point
    logic lerp_a;     // first level of lerps
    logic lerp_b;     // second level
    logic lerp_c;     // final lerp and output rounding
    logic last_t;     // force t to one
  } cbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } cbt_sts_t;
endpackage

[rtl/cubic_bezier_curve_tessellator_unit.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_curve_tessellator_unit: cubic bezier points by de casteljau
// one request word in, point_count (capped at MAX_POINTS) point words out, cyan to magenta color
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   four control points, point count
// out      output     out_valid / out_stall position q12.8, color, index, last
//
// a request first runs the step divider (17 quotient bits, one a cycle, then a
// done state), then each point passes t latch, three lerp levels and output
// word; a count of one skips the divider, a count of zero emits no words
// synchronous active-low reset clears the sequencer only
// a stalled output word holds the sequencer; no new request until run ends
module cubic_bezier_curve_tessellator_unit #(
  parameter int MAX_POINTS = cbt_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cbt_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbt_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_BITS-1:0] in_p0_x, in_p0_y, in_p1_x, in_p1_y,
  input  logic signed [COORD_BITS-1:0] in_p2_x, in_p2_y, in_p3_x, in_p3_y,
  input  logic [cbt_pkg::CNT_W-1:0] in_point_count,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COORD_BITS+7:0] out_x_position,
  output logic signed [COORD_BITS+7:0] out_y_position,
  output logic [cbt_pkg::COL_W-1:0] out_red, out_green, out_blue, out_opacity,
  output logic [cbt_pkg::IDX_W-1:0] out_point_index,
  output logic out_last_point
);
  import cbt_pkg::*;

  cbt_cmd_t cmd;
  cbt_sts_t sts;
  logic [CNT_W-1:0] div_n;
  logic [7:0] sum;

  // sequencer
  cbt_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_point_count, .div_n,
    .cmd, .sts, .out_valid, .out_stall,
    .idx(out_point_index), .last(out_last_point)
  );

  // divider, t and lerp datapath
  cbt_datapath #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_dp (
    .clk, .cmd, .sts,
    .p0_x(in_p0_x), .p0_y(in_p0_y), .p1_x(in_p1_x), .p1_y(in_p1_y),
    .p2_x(in_p2_x), .p2_y(in_p2_y), .p3_x(in_p3_x), .p3_y(in_p3_y),
    .div_n, .x_pos(out_x_position), .y_pos(out_y_position),
    .red(out_red), .green(out_green), .blue_sum(sum)
  );

  // blue and opacity carry the same saturated sum
  assign out_blue = sum;
  assign out_opacity = sum;
endmodule

[rtl/cbt_datapath.sv]
// ----------------------------------------------------------------------------
// cbt_datapath: step divider, t generator and three-level lerp pipe
// one lerp level per cycle, registered between levels
// ----------------------------------------------------------------------------
module cbt_datapath #(
  parameter int COORD_BITS = cbt_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbt_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  cbt_pkg::cbt_cmd_t cmd,
  output cbt_pkg::cbt_sts_t sts,
  input  logic signed [COORD_BITS-1:0] p0_x, p0_y, p1_x, p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x, p2_y, p3_x, p3_y,
  input  logic [cbt_pkg::CNT_W-1:0] div_n,
  output logic signed [COORD_BITS+7:0] x_pos,
  output logic signed [COORD_BITS+7:0] y_pos,
  output logic [7:0] red, green, blue_sum
);
  import cbt_pkg::*;
  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam int PW = COORD_BITS + GUARD_BITS + 1; // point width
  localparam int DIV_CNT_W = $clog2(TW + 1);

  logic signed [PW-1:0] px_r [4];
  logic signed [PW-1:0] py_r [4];
  logic signed [PW-1:0] ax_r [3], ay_r [3], bx_r [2], by_r [2];
  logic [TW-1:0] t_r, step_r, acc_r, quo_r;
  logic [CNT_W-1:0] dvs_r;
  logic [TW:0] rem_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic signed [COORD_BITS+7:0] x_r, y_r;
  logic [7:0] red_r, grn_r, sum_r;

  function automatic logic signed [PW-1:0] lerp(
    input logic signed [PW-1:0] a, input logic signed [PW-1:0] b,
    input logic [TW-1:0] t);
    logic signed [PW+TW+1:0] prod;
    prod = $signed({{(TW+2){a[PW-1]}}, a}) * $signed({1'b0, (TW+1)'(1) << PARAM_FRAC_BITS})
         + $signed({{(TW+2){b[PW-1]}} , b} - {{(TW+2){a[PW-1]}}, a}) * $signed({2'b0, t})
         + $signed((PW+TW+2)'(1) << (PARAM_FRAC_BITS - 1));
    lerp = PW'(prod >>> PARAM_FRAC_BITS);
  endfunction

  // restoring divide of 2^F by (n-1)
  logic [TW:0] rem_sh;
  logic [TW:0] dvs_ext;
  always_comb begin
    rem_sh = {rem_r[TW-1:0], 1'b0};
    dvs_ext = (TW+1)'(dvs_r);
  end

  assign sts.div_done = (dcnt_r == '0);

  logic signed [PW+1:0] xr, yr;
  logic [TW+8:0] lo_p, hi_p;
  logic [8:0] s9;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r[0] <= PW'(p0_x) <<< GUARD_BITS; py_r[0] <= PW'(p0_y) <<< GUARD_BITS;
      px_r[1] <= PW'(p1_x) <<< GUARD_BITS; py_r[1] <= PW'(p1_y) <<< GUARD_BITS;
      px_r[2] <= PW'(p2_x) <<< GUARD_BITS; py_r[2] <= PW'(p2_y) <<< GUARD_BITS;
      px_r[3] <= PW'(p3_x) <<< GUARD_BITS; py_r[3] <= PW'(p3_y) <<< GUARD_BITS;
      dvs_r  <= div_n - CNT_W'(1);
      rem_r  <= '0;
      quo_r  <= (TW)'(1) << PARAM_FRAC_BITS; // dividend bits shift out of quo
      dcnt_r <= DIV_CNT_W'(TW);
      acc_r  <= '0;
    end else if (cmd.div_step) begin
      // shift dividend msb into remainder
      if ({rem_sh[TW:1], quo_r[TW-1]} >= dvs_ext) begin
        rem_r <= {rem_sh[TW:1], quo_r[TW-1]} - dvs_ext;
        quo_r <= {quo_r[TW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_sh[TW:1], quo_r[TW-1]};
        quo_r <= {quo_r[TW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - DIV_CNT_W'(1);
      if (dcnt_r == DIV_CNT_W'(1)) step_r <= {quo_r[TW-2:0], 1'b0} |
        TW'({rem_sh[TW:1], quo_r[TW-1]} >= dvs_ext);
    end
    if (cmd.pt_start) begin
      t_r   <= cmd.last_t ? (TW'(1) << PARAM_FRAC_BITS) : acc_r;
      acc_r <= acc_r + step_r;
    end
    if (cmd.lerp_a) begin
      for (int k = 0; k < 3; k++) begin
        ax_r[k] <= lerp(px_r[k], px_r[k+1], t_r);
        ay_r[k] <= lerp(py_r[k], py_r[k+1], t_r);
      end
    end
    if (cmd.lerp_b) begin
      for (int k = 0; k < 2; k++) begin
        bx_r[k] <= lerp(ax_r[k], ax_r[k+1], t_r);
        by_r[k] <= lerp(ay_r[k], ay_r[k+1], t_r);
      end
    end
    if (cmd.lerp_c) begin
      x_r <= (COORD_BITS+8)'(xr >>> (GUARD_BITS - 8));
      y_r <= (COORD_BITS+8)'(yr >>> (GUARD_BITS - 8));
      red_r <= hi_p[PARAM_FRAC_BITS+7:PARAM_FRAC_BITS];
      grn_r <= lo_p[PARAM_FRAC_BITS+7:PARAM_FRAC_BITS];
      sum_r <= s9[8] ? 8'hFF : s9[7:0];
    end
  end

  always_comb begin
    xr = (PW+2)'(lerp(bx_r[0], bx_r[1], t_r)) + (PW+2)'(1 << (GUARD_BITS - 9));
    yr = (PW+2)'(lerp(by_r[0], by_r[1], t_r)) + (PW+2)'(1 << (GUARD_BITS - 9));
    hi_p = (TW+9)'(t_r) * (TW+9)'(255);
    lo_p = (TW+9)'((TW)'(1) << PARAM_FRAC_BITS) * (TW+9)'(255) - hi_p;
    s9 = {1'b0, hi_p[PARAM_FRAC_BITS+7:PARAM_FRAC_BITS]}
       + {1'b0, lo_p[PARAM_FRAC_BITS+7:PARAM_FRAC_BITS]};
  end

  assign x_pos = x_r;
  assign y_pos = y_r;
  assign red = red_r;
  assign green = grn_r;
  assign blue_sum = sum_r;
endmodule

[rtl/cbt_ctrl.sv]
// ----------------------------------------------------------------------------
// cbt_ctrl: sequencer for divide, per-point lerp steps and output handshake
// ----------------------------------------------------------------------------
module cbt_ctrl #(
  parameter int MAX_POINTS = cbt_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [cbt_pkg::CNT_W-1:0] in_point_count,
  output logic [cbt_pkg::CNT_W-1:0] div_n,
  output cbt_pkg::cbt_cmd_t cmd,
  input  cbt_pkg::cbt_sts_t sts,
  output logic out_valid,
  input  logic out_stall,
  output logic [cbt_pkg::IDX_W-1:0] idx,
  output logic last
);
  import cbt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DIV = 7'b0000010, S_T = 7'b0000100,
    S_LA = 7'b0001000, S_LB = 7'b0010000, S_LC = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, i_r, i_nxt;
  logic [CNT_W-1:0] nsat;
  logic acc;

  always_comb begin
    nsat = (in_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : in_point_count;
    acc = in_valid && !in_stall;
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign idx = IDX_W'(i_r);
  assign last = (i_r + CNT_W'(1) == n_r);
  assign div_n = nsat;

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; i_nxt = i_r;
    cmd = '0;
    unique case (st_r)
      S_IDLE: if (acc) begin
        cmd.load = 1'b1; n_nxt = nsat; i_nxt = '0;
        if (nsat == '0) st_nxt = S_IDLE;
        else if (nsat == CNT_W'(1)) st_nxt = S_T;
        else st_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin cmd.div_step = 1'b0; st_nxt = S_T; end
      end
      S_T: begin
        cmd.pt_start = 1'b1;
        cmd.last_t = (n_r > CNT_W'(1)) && (i_r + CNT_W'(1) == n_r);
        st_nxt = S_LA;
      end
      S_LA: begin cmd.lerp_a = 1'b1; st_nxt = S_LB; end
      S_LB: begin cmd.lerp_b = 1'b1; st_nxt = S_LC; end
      S_LC: begin cmd.lerp_c = 1'b1; st_nxt = S_OUT; end
      S_OUT: if (!out_stall) begin
        if (last) st_nxt = S_IDLE;
        else begin i_nxt = i_r + CNT_W'(1); st_nxt = S_T; end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; n_r <= '0; i_r <= '0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; i_r <= i_nxt;
    end
  end
endmodule
